// ===== rtl/rhsl_pkg.sv =====
// Shared widths, constants and types of the RGB to HSL converter.
`timescale 1ns / 1ps
`default_nettype none

package rhsl_pkg;

  // Field widths
  localparam int CHAN_W = 8;
  localparam int SUM_W  = 9;
  localparam int HUE_W  = 15;
  localparam int Q15_W  = 16;
  localparam int SECT_K_W = 11;

  // Divider geometry: 24-bit dividend, 10-bit divisor, 16-bit quotient
  localparam int NUM_W = 24;
  localparam int DEN_W = 10;
  localparam int QUO_W = 16;
  localparam int DIV_STAGES = 8;
  localparam int DIV_STEPS = QUO_W / DIV_STAGES;

  // Divider lanes
  localparam int LANES = 2;
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  // Constants of the conversion
  localparam logic [SUM_W-1:0] SUM_HALF    = 9'd255;
  localparam logic [SUM_W-1:0] SUM_FULL    = 9'd510;
  localparam logic [DEN_W-1:0] LIGHT_DEN   = 10'd510;
  localparam logic [14:0]      LIGHT_ROUND = 15'd127;
  localparam logic [QUO_W-1:0] HUE_TURN    = 16'd23040;
  localparam logic [Q15_W-1:0] Q15_ONE     = 16'd32768;

  // Which channel holds the maximum
  typedef enum logic [2:0] {
    SECT_RED   = 3'b001,
    SECT_GREEN = 3'b010,
    SECT_BLUE  = 3'b100
  } hue_sector_t;

  typedef logic [LANES-1:0][NUM_W-1:0] div_num_t;
  typedef logic [LANES-1:0][DEN_W-1:0] div_den_t;
  typedef logic [LANES-1:0][QUO_W-1:0] div_quo_t;

endpackage

`default_nettype wire

// ===== rtl/rhsl_div_pipe.sv =====
// Pipelined two-lane restoring divider, two quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none

module rhsl_div_pipe
  import rhsl_pkg::*;
(
  input  wire                   clk,
  input  wire  [DIV_STAGES-1:0] en,
  input  wire  div_num_t        num_in,
  input  wire  div_den_t        den_in,
  input  wire                   gray_in,
  output div_quo_t              quot,
  output logic                  gray_out
);

  // Per-stage partial remainder, shifting dividend/quotient word and divisor
  div_den_t rem_q [DIV_STAGES];
  div_quo_t nq_q  [DIV_STAGES];
  div_den_t den_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] gray_q;

  genvar s;
  for (s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_den_t rem_src;
    div_quo_t nq_src;
    div_den_t den_src;
    logic     gray_src;
    div_den_t rem_next;
    div_quo_t nq_next;

    if (s == 0) begin : g_first
      // Upper dividend bits seed the remainder; they are below the divisor
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_src[l] = DEN_W'(num_in[l][NUM_W-1:QUO_W]);
          nq_src[l]  = num_in[l][QUO_W-1:0];
        end
        den_src  = den_in;
        gray_src = gray_in;
      end
    end else begin : g_next
      always_comb begin
        rem_src  = rem_q[s-1];
        nq_src   = nq_q[s-1];
        den_src  = den_q[s-1];
        gray_src = gray_q[s-1];
      end
    end

    // Compare-subtract steps of this stage
    always_comb begin
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] nq;
      logic [DEN_W:0]   shifted;
      logic             qbit;
      for (int l = 0; l < LANES; l++) begin
        rem = rem_src[l];
        nq  = nq_src[l];
        for (int k = 0; k < DIV_STEPS; k++) begin
          shifted = {rem, nq[QUO_W-1]};
          if (shifted >= {1'b0, den_src[l]}) begin
            rem  = DEN_W'(shifted - {1'b0, den_src[l]});
            qbit = 1'b1;
          end else begin
            rem  = shifted[DEN_W-1:0];
            qbit = 1'b0;
          end
          nq = {nq[QUO_W-2:0], qbit};
        end
        rem_next[l] = rem;
        nq_next[l]  = nq;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_q[s]  <= rem_next;
        nq_q[s]   <= nq_next;
        den_q[s]  <= den_src;
        gray_q[s] <= gray_src;
      end
    end
  end

  assign quot     = nq_q[DIV_STAGES-1];
  assign gray_out = gray_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsl_pixel_converter_top.sv =====
// An accepted input word passes stages 0 to 2, the divider stages and the output stage before its result word.
// Throughput: one word per cycle unless output back-pressure stalls; a new word enters while older ones are in flight.
// Each stage loads when it is empty or its successor loads; only output back-pressure stalls.
// Divides run in an 8-stage restoring divider, two quotient bits per stage per lane.
// Reset (rst, synchronous) clears the stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_pixel_converter_top
  import rhsl_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [CHAN_W-1:0] red_in,
  input  wire  [CHAN_W-1:0] green_in,
  input  wire  [CHAN_W-1:0] blue_in,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [HUE_W-1:0]  hue_out,
  output logic [Q15_W-1:0]  saturation_out,
  output logic [Q15_W-1:0]  lightness_out
);

  localparam int NSTG = DIV_STAGES + 4;
  localparam int ST_DIV0 = 3;
  localparam int ST_OUT = NSTG - 1;

  // Stage valid bits and load enables
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_next;
  logic [NSTG-1:0] load;

  always_comb begin
    load[ST_OUT] = !vld[ST_OUT] || out_ready;
    for (int i = ST_OUT - 1; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign vld_next = (load & {vld[NSTG-2:0], in_valid}) | (~load & vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[ST_OUT];

  // Stage 0: max, min, delta, sum and the sector of the maximum
  hue_sector_t             sect0, sect0_next;
  logic [CHAN_W-1:0]       d0;
  logic [SUM_W-1:0]        sum0;
  logic signed [SUM_W-1:0] diff0, diff0_next;
  logic [CHAN_W-1:0]       mx, mn;

  always_comb begin
    if (red_in >= green_in && red_in >= blue_in) begin
      sect0_next = SECT_RED;
      mx         = red_in;
      diff0_next = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
    end else if (green_in >= blue_in) begin
      sect0_next = SECT_GREEN;
      mx         = green_in;
      diff0_next = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
    end else begin
      sect0_next = SECT_BLUE;
      mx         = blue_in;
      diff0_next = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
    end
    if (red_in <= green_in && red_in <= blue_in) begin
      mn = red_in;
    end else if (green_in <= blue_in) begin
      mn = green_in;
    end else begin
      mn = blue_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      sect0 <= sect0_next;
      d0    <= mx - mn;
      sum0  <= {1'b0, mx} + {1'b0, mn};
      diff0 <= diff0_next;
    end
  end

  // Stage 1: hue numerator in sixths of a turn per unit delta, wrapped non-negative
  logic [SECT_K_W-1:0] k1;
  logic [CHAN_W-1:0]   d1;
  logic [SUM_W-1:0]    sum1;
  logic                gray1;
  logic signed [11:0]  kx;
  logic signed [11:0]  dx;
  logic signed [11:0]  ex;
  logic [CHAN_W-1:0]   lq1;
  logic [14:0]         lz;
  logic [30:0]         lprod;

  always_comb begin
    dx = $signed({4'b0, d0});
    ex = $signed({{3{diff0[SUM_W-1]}}, diff0});
    case (sect0)
      SECT_RED: begin
        kx = ex;
        if (kx < 0) begin
          kx = kx + (dx <<< 2) + (dx <<< 1);
        end
      end
      SECT_GREEN: kx = (dx <<< 1) + ex;
      SECT_BLUE:  kx = (dx <<< 2) + ex;
      default:    kx = '0;
    endcase
  end

  // Lightness is 64*sum + (64*sum + 127)/255; the divide by 255 is a
  // multiply by 32897 = 2^15 + 2^7 + 1 and a shift by 23, exact below 2^15
  always_comb begin
    lz    = {sum0, 6'b0} + LIGHT_ROUND;
    lprod = (31'(lz) << 15) + (31'(lz) << 7) + 31'(lz);
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      k1    <= kx[SECT_K_W-1:0];
      d1    <= d0;
      sum1  <= sum0;
      gray1 <= (d0 == '0);
      lq1   <= lprod[30:23];
    end
  end

  // Stage 2: dividends and divisors of the two quotients, lightness word
  div_num_t         num2;
  div_den_t         den2;
  logic             gray2;
  logic [SUM_W-1:0] sden;
  logic [Q15_W-1:0] light2;

  always_comb begin
    sden = (sum1 < SUM_HALF) ? sum1 : SUM_FULL - sum1;
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      // 2*3840*k + d over 2*d
      num2[LANE_HUE] <= (NUM_W'(k1) << 13) - (NUM_W'(k1) << 9) + NUM_W'(d1);
      den2[LANE_HUE] <= {1'b0, d1, 1'b0};
      // 2*d*32768 + den over 2*den
      num2[LANE_SAT] <= {d1, 16'b0} + NUM_W'(sden);
      den2[LANE_SAT] <= {sden, 1'b0};
      light2         <= {1'b0, sum1, 6'b0} + {8'b0, lq1};
      gray2          <= gray1;
    end
  end

  // Stages 3 to 10: divider, lightness rides alongside
  div_quo_t         quot;
  logic             gray_div;
  logic [Q15_W-1:0] light_dly [DIV_STAGES];

  rhsl_div_pipe u_div (
    .clk      (clk),
    .en       (load[ST_OUT-1:ST_DIV0]),
    .num_in   (num2),
    .den_in   (den2),
    .gray_in  (gray2),
    .quot     (quot),
    .gray_out (gray_div)
  );

  always_ff @(posedge clk) begin
    if (load[ST_DIV0]) begin
      light_dly[0] <= light2;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (load[ST_DIV0+s]) begin
        light_dly[s] <= light_dly[s-1];
      end
    end
  end

  // Output stage: gray and full-turn cases, result word register
  always_ff @(posedge clk) begin
    if (load[ST_OUT]) begin
      if (gray_div || quot[LANE_HUE] >= HUE_TURN) begin
        hue_out <= '0;
      end else begin
        hue_out <= quot[LANE_HUE][HUE_W-1:0];
      end
      saturation_out <= gray_div ? '0 : quot[LANE_SAT];
      lightness_out  <= light_dly[DIV_STAGES-1];
    end
  end

  // Checks
  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, hue_out} < HUE_TURN))
    else $error("hue word out of range");

  a_q15_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (saturation_out <= Q15_ONE && lightness_out <= Q15_ONE))
    else $error("saturation or lightness above 1.0");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

`default_nettype wire
